// ===== hdl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// Default widths and the index tables that wire the cofactor products and
// the adjugate transpose.
// ----------------------------------------------------------------------------
package mi3_pkg;

	// Default word width and fraction bits (signed Q16.16).
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Matrix shape: nine entries, three per row.
	localparam int N_ENT  = 9;
	localparam int N_ROW  = 3;
	localparam int N_PROD = 18;

	// Cofactor k is PROD_L[2k]*PROD_R[2k] - PROD_L[2k+1]*PROD_R[2k+1], with the
	// checkerboard sign already folded into the order of the two products.
	localparam logic [3:0] PROD_L [N_PROD] = '{
		4'd4, 4'd5,  4'd5, 4'd3,  4'd3, 4'd4,
		4'd2, 4'd1,  4'd0, 4'd2,  4'd1, 4'd0,
		4'd1, 4'd2,  4'd2, 4'd0,  4'd0, 4'd1
	};
	localparam logic [3:0] PROD_R [N_PROD] = '{
		4'd8, 4'd7,  4'd6, 4'd8,  4'd7, 4'd6,
		4'd7, 4'd8,  4'd8, 4'd6,  4'd6, 4'd7,
		4'd5, 4'd4,  4'd3, 4'd5,  4'd4, 4'd3
	};

	// Inverse entry r*3+c takes cofactor c*3+r (the adjugate is the transpose).
	localparam logic [3:0] ADJ_IDX [N_ENT] = '{
		4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
	};

endpackage

// ===== hdl/mi3_cofactor.sv =====
// ----------------------------------------------------------------------------
// mi3_cofactor: cofactor stages
// Two pipeline stages: the eighteen entry products, then the nine signed
// cofactors. Row 0 of the matrix travels along for the determinant.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
	parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  a [mi3_pkg::N_ENT],
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [2*DATA_WIDTH:0]  cof [mi3_pkg::N_ENT],
	output logic signed [DATA_WIDTH-1:0]  row0 [mi3_pkg::N_ROW]
);

	localparam int PW     = 2 * DATA_WIDTH;
	localparam int CW     = PW + 1;
	localparam int STAGES = 2;

	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] adv;

	logic signed [PW-1:0]         prod_s1 [mi3_pkg::N_PROD];
	logic signed [DATA_WIDTH-1:0] row0_s1 [mi3_pkg::N_ROW];
	logic signed [CW-1:0]         cof_s2  [mi3_pkg::N_ENT];
	logic signed [DATA_WIDTH-1:0] row0_s2 [mi3_pkg::N_ROW];

	// A stage moves on when it is empty or the stage after it moves on.
	always_comb begin
		adv[STAGES-1] = !vld_s[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			if (adv[1]) begin
				vld_s[1] <= vld_s[0];
			end
		end
	end

	// Stage 1 forms the products, stage 2 the cofactor differences.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < mi3_pkg::N_PROD; i++) begin
				prod_s1[i] <= PW'(a[mi3_pkg::PROD_L[i]]) * PW'(a[mi3_pkg::PROD_R[i]]);
			end
			for (int r = 0; r < mi3_pkg::N_ROW; r++) begin
				row0_s1[r] <= a[r];
			end
		end
		if (adv[1]) begin
			for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
				cof_s2[k] <= CW'(prod_s1[2*k]) - CW'(prod_s1[2*k+1]);
			end
			row0_s2 <= row0_s1;
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign cof       = cof_s2;
	assign row0      = row0_s2;

endmodule

// ===== hdl/mi3_det.sv =====
// ----------------------------------------------------------------------------
// mi3_det: determinant stages
// Expands the determinant along row 0 with split partial products, then
// turns the determinant and the cofactors into magnitudes and signs and
// forms the saturated determinant output.
// ----------------------------------------------------------------------------
module mi3_det #(
	parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [2*DATA_WIDTH:0]  cof [mi3_pkg::N_ENT],
	input  logic signed [DATA_WIDTH-1:0]  row0 [mi3_pkg::N_ROW],
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2*DATA_WIDTH-1:0]       cmag [mi3_pkg::N_ENT],
	output logic [mi3_pkg::N_ENT-1:0]     cneg,
	output logic [3*DATA_WIDTH-1:0]       dmag,
	output logic signed [DATA_WIDTH-1:0]  detv,
	output logic                          sing
);

	localparam int CW     = 2 * DATA_WIDTH + 1;
	localparam int PPW    = 2 * DATA_WIDTH + 1;
	localparam int DW     = 3 * DATA_WIDTH + 1;
	localparam int MW     = 3 * DATA_WIDTH;
	localparam int STAGES = 4;
	localparam logic [DW-1:0] MAXP = (DW'(1) << (DATA_WIDTH - 1)) - DW'(1);
	localparam logic signed [DATA_WIDTH-1:0] MAXP_W = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MINN_W = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] adv;

	logic signed [PPW-1:0] pph_s1 [mi3_pkg::N_ROW];
	logic signed [PPW-1:0] ppl_s1 [mi3_pkg::N_ROW];
	logic signed [CW-1:0]  cof_s1 [mi3_pkg::N_ENT];
	logic signed [DW-1:0]  term_s2 [mi3_pkg::N_ROW];
	logic signed [CW-1:0]  cof_s2 [mi3_pkg::N_ENT];
	logic signed [DW-1:0]  det_s3;
	logic signed [CW-1:0]  cof_s3 [mi3_pkg::N_ENT];

	logic [2*DATA_WIDTH-1:0]      cmag_s4 [mi3_pkg::N_ENT];
	logic [mi3_pkg::N_ENT-1:0]    cneg_s4;
	logic [MW-1:0]                dmag_s4;
	logic signed [DATA_WIDTH-1:0] detv_s4;
	logic                         sing_s4;

	logic signed [DW-1:0]         dabs;
	logic [DW-1:0]                dsh;
	logic signed [DATA_WIDTH-1:0] detv_c;
	logic signed [CW-1:0]         cabs [mi3_pkg::N_ENT];

	// Stall chain: a stage moves on when it is empty or its successor moves.
	always_comb begin
		adv[STAGES-1] = !vld_s[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Magnitudes, signs and the saturated determinant for the last stage.
	always_comb begin
		dabs = det_s3[DW-1] ? -det_s3 : det_s3;
		dsh  = dabs >> (2 * FRAC_BITS);
		if (!det_s3[DW-1]) begin
			detv_c = (dsh > MAXP) ? MAXP_W : $signed(dsh[DATA_WIDTH-1:0]);
		end else begin
			detv_c = (dsh > MAXP + DW'(1)) ? MINN_W : -$signed(dsh[DATA_WIDTH-1:0]);
		end
		for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
			cabs[k] = cof_s3[k][CW-1] ? -cof_s3[k] : cof_s3[k];
		end
	end

	// Each row 0 product is split over the high and low halves of its
	// cofactor, so no multiplier is wider than one word plus a bit.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int j = 0; j < mi3_pkg::N_ROW; j++) begin
				pph_s1[j] <= PPW'(row0[j]) * PPW'($signed(cof[j][CW-1:DATA_WIDTH]));
				ppl_s1[j] <= PPW'(row0[j]) * PPW'($signed({1'b0, cof[j][DATA_WIDTH-1:0]}));
			end
			cof_s1 <= cof;
		end
		if (adv[1]) begin
			for (int j = 0; j < mi3_pkg::N_ROW; j++) begin
				term_s2[j] <= (DW'(pph_s1[j]) <<< DATA_WIDTH) + DW'(ppl_s1[j]);
			end
			cof_s2 <= cof_s1;
		end
		if (adv[2]) begin
			det_s3 <= term_s2[0] + term_s2[1] + term_s2[2];
			cof_s3 <= cof_s2;
		end
		if (adv[3]) begin
			dmag_s4 <= dabs[MW-1:0];
			sing_s4 <= (det_s3 == '0);
			detv_s4 <= detv_c;
			for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
				cmag_s4[k] <= cabs[k][2*DATA_WIDTH-1:0];
				cneg_s4[k] <= cof_s3[k][CW-1] ^ det_s3[DW-1];
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign cmag      = cmag_s4;
	assign cneg      = cneg_s4;
	assign dmag      = dmag_s4;
	assign detv      = detv_s4;
	assign sing      = sing_s4;

endmodule

// ===== hdl/mi3_divider.sv =====
// ----------------------------------------------------------------------------
// mi3_divider: pipelined restoring divider, nine lanes
// Divides each cofactor magnitude, scaled by two to the power of twice the
// fraction bits, by the determinant magnitude. One quotient bit per stage;
// quotients that do not fit one word are flagged for saturation.
// ----------------------------------------------------------------------------
module mi3_divider #(
	parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2*DATA_WIDTH-1:0]       cmag [mi3_pkg::N_ENT],
	input  logic [mi3_pkg::N_ENT-1:0]     cneg,
	input  logic [3*DATA_WIDTH-1:0]       dmag,
	input  logic signed [DATA_WIDTH-1:0]  detv,
	input  logic                          sing,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DATA_WIDTH-1:0]         quo [mi3_pkg::N_ENT],
	output logic [mi3_pkg::N_ENT-1:0]     qovf,
	output logic [mi3_pkg::N_ENT-1:0]     qneg,
	output logic signed [DATA_WIDTH-1:0]  detv_out,
	output logic                          sing_out
);

	localparam int RW     = 3 * DATA_WIDTH;
	localparam int NW     = 2 * DATA_WIDTH + 2 * FRAC_BITS;
	localparam int HW     = NW - DATA_WIDTH;
	localparam int CMPW   = (HW > RW) ? HW : RW;
	localparam int STAGES = DATA_WIDTH + 1;

	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] adv;

	// One row of registers per stage; the stage number is the first index.
	logic [RW-1:0]                rem_s  [STAGES][mi3_pkg::N_ENT];
	logic [DATA_WIDTH-1:0]        nl_s   [STAGES][mi3_pkg::N_ENT];
	logic [DATA_WIDTH-1:0]        q_s    [STAGES][mi3_pkg::N_ENT];
	logic [mi3_pkg::N_ENT-1:0]    ovf_s  [STAGES];
	logic [mi3_pkg::N_ENT-1:0]    neg_s  [STAGES];
	logic [RW-1:0]                dmag_s [STAGES];
	logic signed [DATA_WIDTH-1:0] detv_s [STAGES];
	logic [STAGES-1:0]            sing_s;

	logic [RW-1:0]             nrem [STAGES][mi3_pkg::N_ENT];
	logic [DATA_WIDTH-1:0]     nq   [STAGES][mi3_pkg::N_ENT];
	logic [DATA_WIDTH-1:0]     nnl  [mi3_pkg::N_ENT];
	logic [mi3_pkg::N_ENT-1:0] novf;
	logic [NW-1:0]             num;
	logic [CMPW-1:0]           nh;
	logic [RW:0]               trial;
	logic [RW:0]               diff;

	always_comb begin
		adv[STAGES-1] = !vld_s[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Next values for every stage. The first stage checks for quotient
	// overflow and loads the top of the numerator as partial remainder;
	// each later stage brings down one numerator bit and tries a subtract.
	always_comb begin
		num   = '0;
		nh    = '0;
		trial = '0;
		diff  = '0;
		for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
			num        = NW'(cmag[k]) << (2 * FRAC_BITS);
			nh         = CMPW'(num[NW-1:DATA_WIDTH]);
			novf[k]    = (nh >= CMPW'(dmag));
			nrem[0][k] = nh[RW-1:0];
			nnl[k]     = num[DATA_WIDTH-1:0];
			nq[0][k]   = '0;
		end
		for (int s = 1; s < STAGES; s++) begin
			for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
				trial = {rem_s[s-1][k], nl_s[s-1][k][DATA_WIDTH-s]};
				diff  = trial - {1'b0, dmag_s[s-1]};
				if (trial >= {1'b0, dmag_s[s-1]}) begin
					nrem[s][k] = diff[RW-1:0];
					nq[s][k]   = {q_s[s-1][k][DATA_WIDTH-2:0], 1'b1};
				end else begin
					nrem[s][k] = trial[RW-1:0];
					nq[s][k]   = {q_s[s-1][k][DATA_WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0]  <= nrem[0];
			q_s[0]    <= nq[0];
			nl_s[0]   <= nnl;
			ovf_s[0]  <= novf;
			neg_s[0]  <= cneg;
			dmag_s[0] <= dmag;
			detv_s[0] <= detv;
			sing_s[0] <= sing;
		end
		for (int s = 1; s < STAGES; s++) begin
			if (adv[s]) begin
				rem_s[s]  <= nrem[s];
				q_s[s]    <= nq[s];
				nl_s[s]   <= nl_s[s-1];
				ovf_s[s]  <= ovf_s[s-1];
				neg_s[s]  <= neg_s[s-1];
				dmag_s[s] <= dmag_s[s-1];
				detv_s[s] <= detv_s[s-1];
				sing_s[s] <= sing_s[s-1];
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign quo       = q_s[STAGES-1];
	assign qovf      = ovf_s[STAGES-1];
	assign qneg      = neg_s[STAGES-1];
	assign detv_out  = detv_s[STAGES-1];
	assign sing_out  = sing_s[STAGES-1];

endmodule

// ===== hdl/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 matrix inverse by adjugate
// Signed fixed-point inverse, determinant and singular flag of one matrix
// per request, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one matrix per request (a00..a22, signed, with
//   FRAC_BITS fraction bits); a request is taken on a clock edge with
//   in_valid high and in_stall low. The output channel returns one result
//   per request in order (b00..b22, det_value, singular) under
//   out_valid/out_stall with the same rule.
//   The path holds two cofactor stages, four determinant stages,
//   DATA_WIDTH + 1 divider stages at one quotient bit each, and the output
//   register. Throughput is one request per cycle while out_stall is low,
//   set by the divider doing one bit per stage in every lane.
//   While out_stall is high a held result stays put; empty stages further
//   up still fill, and in_stall rises only once every stage holds a request.
//   A zero determinant gives singular = 1 with all outputs zero; entries
//   beyond the output range saturate.
//   Reset clears all valid bits; the pipeline is empty and ready at once.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
	parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  a00,
	input  logic signed [DATA_WIDTH-1:0]  a01,
	input  logic signed [DATA_WIDTH-1:0]  a02,
	input  logic signed [DATA_WIDTH-1:0]  a10,
	input  logic signed [DATA_WIDTH-1:0]  a11,
	input  logic signed [DATA_WIDTH-1:0]  a12,
	input  logic signed [DATA_WIDTH-1:0]  a20,
	input  logic signed [DATA_WIDTH-1:0]  a21,
	input  logic signed [DATA_WIDTH-1:0]  a22,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  b00,
	output logic signed [DATA_WIDTH-1:0]  b01,
	output logic signed [DATA_WIDTH-1:0]  b02,
	output logic signed [DATA_WIDTH-1:0]  b10,
	output logic signed [DATA_WIDTH-1:0]  b11,
	output logic signed [DATA_WIDTH-1:0]  b12,
	output logic signed [DATA_WIDTH-1:0]  b20,
	output logic signed [DATA_WIDTH-1:0]  b21,
	output logic signed [DATA_WIDTH-1:0]  b22,
	output logic signed [DATA_WIDTH-1:0]  det_value,
	output logic                          singular
);

	localparam logic signed [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MINN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [DATA_WIDTH-1:0]  a_in [mi3_pkg::N_ENT];

	logic                          cf_valid;
	logic                          cf_stall;
	logic signed [2*DATA_WIDTH:0]  cf_cof [mi3_pkg::N_ENT];
	logic signed [DATA_WIDTH-1:0]  cf_row0 [mi3_pkg::N_ROW];

	logic                          dt_valid;
	logic                          dt_stall;
	logic [2*DATA_WIDTH-1:0]       dt_cmag [mi3_pkg::N_ENT];
	logic [mi3_pkg::N_ENT-1:0]     dt_cneg;
	logic [3*DATA_WIDTH-1:0]       dt_dmag;
	logic signed [DATA_WIDTH-1:0]  dt_detv;
	logic                          dt_sing;

	logic                          dv_valid;
	logic                          dv_stall;
	logic [DATA_WIDTH-1:0]         dv_quo [mi3_pkg::N_ENT];
	logic [mi3_pkg::N_ENT-1:0]     dv_ovf;
	logic [mi3_pkg::N_ENT-1:0]     dv_neg;
	logic signed [DATA_WIDTH-1:0]  dv_detv;
	logic                          dv_sing;

	logic signed [DATA_WIDTH-1:0]  b_c [mi3_pkg::N_ENT];
	logic signed [DATA_WIDTH-1:0]  b_q [mi3_pkg::N_ENT];
	logic signed [DATA_WIDTH-1:0]  det_q;
	logic                          sing_q;
	logic                          out_vld_q;
	logic                          out_adv;
	logic [DATA_WIDTH-1:0]         qv;
	logic [3:0]                    lane;

	assign a_in[0] = a00;
	assign a_in[1] = a01;
	assign a_in[2] = a02;
	assign a_in[3] = a10;
	assign a_in[4] = a11;
	assign a_in[5] = a12;
	assign a_in[6] = a20;
	assign a_in[7] = a21;
	assign a_in[8] = a22;

	mi3_cofactor #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_cofactor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.a         (a_in),
		.out_valid (cf_valid),
		.out_stall (cf_stall),
		.cof       (cf_cof),
		.row0      (cf_row0)
	);

	mi3_det #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cf_valid),
		.in_stall  (cf_stall),
		.cof       (cf_cof),
		.row0      (cf_row0),
		.out_valid (dt_valid),
		.out_stall (dt_stall),
		.cmag      (dt_cmag),
		.cneg      (dt_cneg),
		.dmag      (dt_dmag),
		.detv      (dt_detv),
		.sing      (dt_sing)
	);

	mi3_divider #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dt_valid),
		.in_stall  (dt_stall),
		.cmag      (dt_cmag),
		.cneg      (dt_cneg),
		.dmag      (dt_dmag),
		.detv      (dt_detv),
		.sing      (dt_sing),
		.out_valid (dv_valid),
		.out_stall (dv_stall),
		.quo       (dv_quo),
		.qovf      (dv_ovf),
		.qneg      (dv_neg),
		.detv_out  (dv_detv),
		.sing_out  (dv_sing)
	);

	// The output register loads when it is empty or its result is taken.
	assign out_adv  = !out_vld_q || !out_stall;
	assign dv_stall = !out_adv;

	// Transpose into the adjugate, apply the sign and saturate; a singular
	// matrix forces every entry to zero.
	always_comb begin
		qv   = '0;
		lane = '0;
		for (int i = 0; i < mi3_pkg::N_ENT; i++) begin
			lane = mi3_pkg::ADJ_IDX[i];
			qv   = dv_quo[lane];
			if (dv_sing) begin
				b_c[i] = '0;
			end else if (!dv_neg[lane]) begin
				b_c[i] = (dv_ovf[lane] || qv[DATA_WIDTH-1]) ? MAXP : $signed(qv);
			end else if (dv_ovf[lane] || (qv[DATA_WIDTH-1] && |qv[DATA_WIDTH-2:0])) begin
				b_c[i] = MINN;
			end else begin
				b_c[i] = -$signed(qv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			b_q    <= b_c;
			det_q  <= dv_sing ? '0 : dv_detv;
			sing_q <= dv_sing;
		end
	end

	assign out_valid = out_vld_q;
	assign b00       = b_q[0];
	assign b01       = b_q[1];
	assign b02       = b_q[2];
	assign b10       = b_q[3];
	assign b11       = b_q[4];
	assign b12       = b_q[5];
	assign b20       = b_q[6];
	assign b21       = b_q[7];
	assign b22       = b_q[8];
	assign det_value = det_q;
	assign singular  = sing_q;

	// An empty output register means the whole stall chain is open.
	a_ready_when_out_empty : assert property (
		@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall
	) else $error("input stalled while the output register is empty");

	// A singular result carries a zero determinant and zero entries.
	a_singular_zero : assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid && singular |->
			(det_value == '0 && b00 == '0 && b11 == '0 && b22 == '0 && b12 == '0)
	) else $error("singular result with nonzero outputs");

	// A result taken with no successor waiting leaves the output empty.
	a_drain : assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !dv_valid |=> !out_valid
	) else $error("output valid held after the result was taken");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for matrix3x3_inverse
// Drives directed and random 3x3 matrices with random gaps and output stalls.
// An exact wide-integer model of the adjugate inverse predicts each result,
// and every returned result is checked field by field in request order.
// ----------------------------------------------------------------------------
module tb;

	localparam int W       = mi3_pkg::DATA_WIDTH_DEF;
	localparam int F       = mi3_pkg::FRAC_BITS_DEF;
	localparam int N_RAND  = 1030;
	localparam int WD_MAX  = 3000;
	localparam logic [W-1:0] ONE  = 1 << F;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef logic [8:0][W-1:0] matrix_t;
	typedef struct packed {
		logic [8:0][W-1:0] b;
		logic [W-1:0]      det;
		logic              sing;
	} inverse_t;
	typedef struct {
		matrix_t  m;
		bit       known;
		inverse_t r;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b1;
	matrix_t mat_in = '0;
	inverse_t inv_out;

	inverse_t pending_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int singular_seen = 0;
	int idle_cycles = 0;
	bit sending_done = 1'b0;
	bit burst_mode = 1'b0;

	always #6 clk = ~clk;

	matrix3x3_inverse i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a00(mat_in[0]), .a01(mat_in[1]), .a02(mat_in[2]),
		.a10(mat_in[3]), .a11(mat_in[4]), .a12(mat_in[5]),
		.a20(mat_in[6]), .a21(mat_in[7]), .a22(mat_in[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.b00(inv_out.b[0]), .b01(inv_out.b[1]), .b02(inv_out.b[2]),
		.b10(inv_out.b[3]), .b11(inv_out.b[4]), .b12(inv_out.b[5]),
		.b20(inv_out.b[6]), .b21(inv_out.b[7]), .b22(inv_out.b[8]),
		.det_value(inv_out.det), .singular(inv_out.sing)
	);

	// Clamp an exact value to the signed output word.
	function automatic logic [W-1:0] clamp(logic signed [127:0] x);
		if (x > $signed({96'd0, MAXV}))
			return MAXV;
		if (x < -$signed({96'd0, MAXV}) - 1)
			return MINV;
		return x[W-1:0];
	endfunction

	// Exact adjugate inverse: cofactors, row-0 determinant, truncating divide.
	function automatic inverse_t adjugate_inverse(matrix_t m);
		logic signed [127:0] a[9];
		logic signed [127:0] c[9];
		logic signed [127:0] det;
		inverse_t r;
		for (int i = 0; i < 9; i++)
			a[i] = $signed(m[i]);
		c[0] = a[4] * a[8] - a[5] * a[7];
		c[1] = a[5] * a[6] - a[3] * a[8];
		c[2] = a[3] * a[7] - a[4] * a[6];
		c[3] = a[2] * a[7] - a[1] * a[8];
		c[4] = a[0] * a[8] - a[2] * a[6];
		c[5] = a[1] * a[6] - a[0] * a[7];
		c[6] = a[1] * a[5] - a[2] * a[4];
		c[7] = a[2] * a[3] - a[0] * a[5];
		c[8] = a[0] * a[4] - a[1] * a[3];
		det = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
		r = '0;
		if (det == 0) begin
			r.sing = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				r.b[i*3+k] = clamp((c[k*3+i] <<< (2*F)) / det);
		r.det = clamp(det / (128'sd1 <<< (2*F)));
		return r;
	endfunction

	function automatic matrix_t diagonal(logic [W-1:0] d);
		matrix_t m;
		m = '0;
		m[0] = d;
		m[4] = d;
		m[8] = d;
		return m;
	endfunction

	function automatic logic [W-1:0] rand_word();
		return W'({$urandom, $urandom});
	endfunction

	// Random matrix of one of several shapes: full range, small values,
	// singular by a repeated row, or built from the range extremes.
	function automatic matrix_t random_matrix();
		matrix_t m;
		int shape;
		shape = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			case (shape)
				0, 1, 2: m[i] = rand_word();
				7:       m[i] = $urandom_range(0, 1) ? MAXV : MINV;
				8:       m[i] = W'($signed($urandom_range(0, 6)) - 3);
				default: m[i] = W'($signed($urandom_range(0, 8 << F)) - (4 << F));
			endcase
		end
		if (shape == 6)
			for (int k = 0; k < 3; k++)
				m[$urandom_range(1, 2) * 3 + k] = m[k];
		return m;
	endfunction

	// Present one request, after a random gap, and hold it until it is taken.
	task automatic send_request(matrix_t m);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mat_in <= m;
		do @(posedge clk); while (in_stall);
		pending_q.push_back(adjugate_inverse(m));
	endtask

	// Compare one returned result with the oldest expectation.
	task automatic check_result(inverse_t got);
		inverse_t want;
		results_seen++;
		if (got.sing)
			singular_seen++;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing pending", $realtime);
			return;
		end
		want = pending_q.pop_front();
		for (int i = 0; i < 11; i++) begin
			logic [W-1:0] e;
			logic [W-1:0] g;
			e = (i < 9) ? want.b[i] : (i == 9) ? want.det : W'(want.sing);
			g = (i < 9) ? got.b[i] : (i == 9) ? got.det : W'(got.sing);
			if (e !== g) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d field %0d expected %h got %h",
						$realtime, results_seen, i, e, g);
			end
		end
	endtask

	// Directed stimulus, with the obvious answers typed in.
	vector_t vectors[$];

	initial begin
		vector_t v;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		v.known = 1'b1;
		v.m = diagonal(ONE);
		v.r = '0; v.r.b[0] = ONE; v.r.b[4] = ONE; v.r.b[8] = ONE; v.r.det = ONE;
		vectors.push_back(v);
		v.m = '0;
		v.r = '0; v.r.sing = 1'b1;
		vectors.push_back(v);
		v.m = diagonal(2 << F);
		v.r = '0; v.r.b[0] = ONE >> 1; v.r.b[4] = ONE >> 1; v.r.b[8] = ONE >> 1;
		v.r.det = 8 << F;
		vectors.push_back(v);
		v.m = {9{MAXV}};
		v.r = '0; v.r.sing = 1'b1;
		vectors.push_back(v);
		v.known = 1'b0;
		foreach (v.m[i]) v.m[i] = '0;
		v.m = diagonal(MAXV);
		vectors.push_back(v);
		v.m = diagonal(MINV);
		vectors.push_back(v);
		v.m = diagonal(W'(1));
		vectors.push_back(v);
		v.m = diagonal(-ONE);
		vectors.push_back(v);
		v.m = diagonal(W'(3 << (F - 2)));
		vectors.push_back(v);
		v.m = {9{MINV}};
		vectors.push_back(v);
		v.m = {9{{W{1'b1}}}};
		vectors.push_back(v);
		v.m = {MAXV, W'(0), MINV, W'(0), MINV, MAXV, MINV, MAXV, W'(0)};
		vectors.push_back(v);
		v.m = {ONE, W'(2 << F), W'(3 << F), W'(0), ONE, W'(4 << F),
			W'(5 << F), W'(6 << F), W'(0)};
		vectors.push_back(v);
		v.m = {W'(7), W'(1), W'(5), W'(2), W'(9), W'(3), W'(4), W'(8), W'(6)};
		vectors.push_back(v);

		foreach (vectors[n]) begin
			send_request(vectors[n].m);
			if (vectors[n].known)
				pending_q[pending_q.size() - 1] = vectors[n].r;
		end

		for (int n = 0; n < N_RAND; n++) begin
			if (n % 128 == 0)
				burst_mode = ($urandom_range(0, 2) == 0);
			// Drain the pipeline completely once mid-run.
			if (n == N_RAND / 2) begin
				in_valid <= 1'b0;
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			send_request(random_matrix());
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Result side: random stall before each result, then take it.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = burst_mode ? 0 : $urandom_range(0, 11);
			repeat (hold) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			check_result(inv_out);
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_MAX) begin
			$display("timeout with %0d results pending", pending_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// End of run: wait for the queue to empty, then watch for strays.
	initial begin
		wait (sending_done);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (W + 20) @(posedge clk);
		$display("checked %0d matrices (%0d directed), %0d of them singular",
			results_seen, vectors.size(), singular_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
